>>> rtl/core/shpd_pkg.sv
// ---------------------------------------------------------------------------
// shpd_pkg
// shared constants, types and helpers of the side hit pair direction unit
// ---------------------------------------------------------------------------
`default_nettype none

package shpd_pkg;

  localparam int unsigned CoordBitsDef  = 20;
  localparam int unsigned TimeBitsDef   = 48;
  localparam int unsigned ChargeBitsDef = 32;

  localparam int unsigned IdW    = 7;
  localparam int unsigned TolW   = 16;
  localparam int unsigned ZenW   = 13;
  localparam int unsigned AziW   = 15;
  localparam int unsigned DataW  = 64;
  localparam int unsigned AngW   = 32;
  localparam int unsigned Steps  = 16;
  localparam int unsigned StepW  = $clog2(Steps);
  localparam int unsigned GuardTop = 57;
  localparam int unsigned FracW  = 30;
  localparam int unsigned InvW   = 30;

  localparam logic [InvW-1:0]        InvGain   = InvW'(652032874);
  localparam logic signed [AngW-1:0] QuarterAng = AngW'(90 * 65536);
  localparam logic signed [AngW-1:0] RoundHalf  = AngW'(512);
  localparam int unsigned            RoundShift = 10;
  localparam logic signed [AngW-1:0] FullTurn   = AngW'(23040);
  localparam logic signed [AngW-1:0] ZenMax     = AngW'(5760);

  localparam logic signed [AngW-1:0] AtanTab [Steps] = '{
    AngW'(2949120), AngW'(1740967), AngW'(919879), AngW'(466945),
    AngW'(234379),  AngW'(117304),  AngW'(58666),  AngW'(29335),
    AngW'(14668),   AngW'(7334),    AngW'(3667),   AngW'(1833),
    AngW'(917),     AngW'(458),     AngW'(229),    AngW'(115)
  };

  typedef enum logic [2:0] {
    SideNone  = 3'd0,
    SideOne   = 3'd1,
    SideTwo   = 3'd2,
    SideThree = 3'd3,
    SideFour  = 3'd4
  } side_e;

  // controller to datapath
  typedef struct packed {
    logic             ready;
    logic             pre;
    logic             rot;
    logic             mul;
    logic             zinit;
    logic             fin;
    logic [StepW-1:0] step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start;
    logic vert;
    logic out_free;
  } sts_t;

  function automatic side_e side_of(input logic [IdW-1:0] id);
    side_e s;
    s = SideNone;
    if (id <= 7'd11 || (id >= 7'd101 && id <= 7'd112)) begin
      s = SideOne;
    end else if (id >= 7'd12 && id <= 7'd35) begin
      s = SideTwo;
    end else if ((id >= 7'd36 && id <= 7'd47) || (id >= 7'd65 && id <= 7'd76)) begin
      s = SideThree;
    end else if (id >= 7'd77 && id <= 7'd100) begin
      s = SideFour;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/shpd_hit_if.sv
// ---------------------------------------------------------------------------
// shpd_hit_if
// hit channel: valid/ready handshake with one hit per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface shpd_hit_if #(
  parameter int unsigned COORD_BITS  = 20,
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned CHARGE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic                          is_end;
  logic [6:0]                    det_id;
  logic [TIME_BITS-1:0]          hit_time;
  logic signed [COORD_BITS-1:0]  pos_x;
  logic signed [COORD_BITS-1:0]  pos_y;
  logic signed [COORD_BITS-1:0]  pos_z;
  logic [CHARGE_BITS-1:0]        charge;

  modport source (output valid, is_end, det_id, hit_time, pos_x, pos_y, pos_z, charge,
                  input ready);
  modport sink (input valid, is_end, det_id, hit_time, pos_x, pos_y, pos_z, charge,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/shpd_pair_if.sv
// ---------------------------------------------------------------------------
// shpd_pair_if
// result channel: valid/ready handshake with one pair direction per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface shpd_pair_if #(
  parameter int unsigned TIME_BITS   = 48,
  parameter int unsigned CHARGE_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [12:0]            zenith_angle;
  logic [14:0]            azimuth_angle;
  logic [6:0]             upper_id;
  logic [6:0]             lower_id;
  logic [CHARGE_BITS-1:0] upper_charge;
  logic [CHARGE_BITS-1:0] lower_charge;
  logic [TIME_BITS-1:0]   upper_time;
  logic [TIME_BITS-1:0]   lower_time;
  logic [TIME_BITS-1:0]   group_time;
  logic [CHARGE_BITS:0]   charge_sum;

  modport source (output valid, zenith_angle, azimuth_angle, upper_id, lower_id,
                  upper_charge, lower_charge, upper_time, lower_time, group_time,
                  charge_sum, input ready);
  modport sink (input valid, zenith_angle, azimuth_angle, upper_id, lower_id,
                upper_charge, lower_charge, upper_time, lower_time, group_time,
                charge_sum, output ready);
endinterface

`default_nettype wire

>>> rtl/core/shpd_ctrl.sv
// ---------------------------------------------------------------------------
// shpd_ctrl
// sequencer for grouping, the two cordic passes and the result write
// ---------------------------------------------------------------------------
`default_nettype none

module shpd_ctrl
  import shpd_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  sts_t sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPre   = 7'b0000010,
    StAzi   = 7'b0000100,
    StMul   = 7'b0001000,
    StZinit = 7'b0010000,
    StZen   = 7'b0100000,
    StFin   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             step_last;

  assign step_last = (step_q == StepW'(Steps - 1));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (sts_i.start) state_d = sts_i.vert ? StFin : StPre;
      end
      StPre: begin
        step_d  = '0;
        state_d = StAzi;
      end
      StAzi: begin
        step_d = step_q + 1'b1;
        if (step_last) state_d = StMul;
      end
      StMul: begin
        state_d = StZinit;
      end
      StZinit: begin
        step_d  = '0;
        state_d = StZen;
      end
      StZen: begin
        step_d = step_q + 1'b1;
        if (step_last) state_d = StFin;
      end
      StFin: begin
        if (sts_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign cmd_o.ready = (state_q == StIdle);
  assign cmd_o.pre   = (state_q == StPre);
  assign cmd_o.rot   = (state_q == StAzi) || (state_q == StZen);
  assign cmd_o.mul   = (state_q == StMul);
  assign cmd_o.zinit = (state_q == StZinit);
  assign cmd_o.fin   = (state_q == StFin);
  assign cmd_o.step  = step_q;

endmodule

`default_nettype wire

>>> rtl/core/shpd_dp.sv
// ---------------------------------------------------------------------------
// shpd_dp
// group tracking, held side hits, shared cordic stage and result register
// ---------------------------------------------------------------------------
`default_nettype none

module shpd_dp
  import shpd_pkg::*;
#(
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef,
  parameter int unsigned CHARGE_BITS = ChargeBitsDef
) (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  logic            cfg_we_i,
  input  wire  logic [TolW-1:0] cfg_wdata_i,
  shpd_hit_if.sink              hit,
  shpd_pair_if.source           pair,
  input  wire  cmd_t            cmd_i,
  output sts_t                  sts_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned TW    = TIME_BITS;
  localparam int unsigned QW    = CHARGE_BITS;
  localparam int unsigned Guard = GuardTop - COORD_BITS;

  // group state
  logic [TolW-1:0] tol_q;
  logic            open_q, open_d;
  logic [TW-1:0]   start_q, start_d;
  logic [1:0]      cnt_q, cnt_d, cnt_base;

  logic [IdW-1:0]        held_id_q [2];
  logic [TW-1:0]         held_t_q  [2];
  logic signed [CW-1:0]  held_x_q  [2];
  logic signed [CW-1:0]  held_y_q  [2];
  logic signed [CW-1:0]  held_z_q  [2];
  logic [QW-1:0]         held_ch_q [2];

  logic          accept, far, close, emit, up, lo, store;
  logic [TW-1:0] tdiff;

  // pair snapshot
  logic [IdW-1:0]      up_id_q, lo_id_q;
  logic [TW-1:0]       up_t_q, lo_t_q, grp_t_q;
  logic [QW-1:0]       up_ch_q, lo_ch_q;
  logic signed [CW:0]  dx_q, dy_q, dz_q, dx_c, dy_c, dz_c;
  logic                vert_q;

  // cordic
  logic signed [DataW-1:0] x_q, y_q, xs, ys, dxw, dyw, dzw;
  logic signed [AngW-1:0]  acc_q, acc_r, azi_a;
  logic [DataW-1:0]        mag;
  logic [DataW-1:0]        phi_q, plo_q;
  logic [AziW-1:0]         azi_q;
  logic [ZenW-1:0]         zen_c;
  logic                    out_free;

  assign accept = hit.valid && cmd_i.ready;
  assign tdiff  = (hit.hit_time >= start_q) ? (hit.hit_time - start_q)
                                            : (start_q - hit.hit_time);
  assign far    = (tdiff > TW'(tol_q));
  assign close  = accept && open_q && (hit.is_end || far);
  assign up     = (held_z_q[0] > held_z_q[1]) ? 1'b0 : 1'b1;
  assign lo     = ~up;
  assign emit   = close && (cnt_q == 2'd2)
                  && (side_of(held_id_q[0]) != side_of(held_id_q[1]))
                  && (held_z_q[0] != held_z_q[1]);

  assign dx_c = (CW+1)'(held_x_q[up]) - (CW+1)'(held_x_q[lo]);
  assign dy_c = (CW+1)'(held_y_q[up]) - (CW+1)'(held_y_q[lo]);
  assign dz_c = (CW+1)'(held_z_q[up]) - (CW+1)'(held_z_q[lo]);

  assign sts_o.start    = emit;
  assign sts_o.vert     = (dx_c == '0) && (dy_c == '0);
  assign sts_o.out_free = out_free;

  // grouping next state
  always_comb begin
    open_d   = open_q;
    start_d  = start_q;
    cnt_d    = cnt_q;
    cnt_base = cnt_q;
    store    = 1'b0;
    if (accept) begin
      if (hit.is_end) begin
        open_d = 1'b0;
        cnt_d  = '0;
      end else begin
        if (!open_q || far) begin
          open_d   = 1'b1;
          start_d  = hit.hit_time;
          cnt_base = '0;
        end
        cnt_d = cnt_base;
        if (side_of(hit.det_id) != SideNone) begin
          store = (cnt_base < 2'd2);
          if (cnt_base != 2'd3) cnt_d = cnt_base + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= '0;
      open_q  <= 1'b0;
      start_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      open_q  <= open_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      held_id_q[cnt_base[0]] <= hit.det_id;
      held_t_q[cnt_base[0]]  <= hit.hit_time;
      held_x_q[cnt_base[0]]  <= hit.pos_x;
      held_y_q[cnt_base[0]]  <= hit.pos_y;
      held_z_q[cnt_base[0]]  <= hit.pos_z;
      held_ch_q[cnt_base[0]] <= hit.charge;
    end
    if (emit) begin
      up_id_q <= held_id_q[up];
      lo_id_q <= held_id_q[lo];
      up_t_q  <= held_t_q[up];
      lo_t_q  <= held_t_q[lo];
      up_ch_q <= held_ch_q[up];
      lo_ch_q <= held_ch_q[lo];
      grp_t_q <= start_q;
      dx_q    <= dx_c;
      dy_q    <= dy_c;
      dz_q    <= dz_c;
      vert_q  <= (dx_c == '0) && (dy_c == '0);
    end
  end

  // scaled differences
  assign dxw = {{(DataW-CW-1){dx_q[CW]}}, dx_q} <<< Guard;
  assign dyw = {{(DataW-CW-1){dy_q[CW]}}, dy_q} <<< Guard;
  assign dzw = {{(DataW-CW-1){dz_q[CW]}}, dz_q} <<< Guard;

  assign xs  = x_q >>> cmd_i.step;
  assign ys  = y_q >>> cmd_i.step;
  assign mag = (x_q > 0) ? DataW'(x_q) : '0;

  // azimuth rounding and wrap
  always_comb begin
    acc_r = acc_q + RoundHalf;
    azi_a = acc_r >>> RoundShift;
    if (azi_a < 0) begin
      azi_a = azi_a + FullTurn;
    end else if (azi_a >= FullTurn) begin
      azi_a = azi_a - FullTurn;
    end
  end

  // zenith rounding and clamp
  always_comb begin
    if (acc_r < 0) begin
      zen_c = '0;
    end else if ((acc_r >>> RoundShift) > ZenMax) begin
      zen_c = ZenW'(ZenMax);
    end else begin
      zen_c = ZenW'(acc_r >>> RoundShift);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pre) begin
      if (dxw < 0) begin
        if (dyw >= 0) begin
          x_q   <= dyw;
          y_q   <= -dxw;
          acc_q <= QuarterAng;
        end else begin
          x_q   <= -dyw;
          y_q   <= dxw;
          acc_q <= -QuarterAng;
        end
      end else begin
        x_q   <= dxw;
        y_q   <= dyw;
        acc_q <= '0;
      end
    end else if (cmd_i.rot) begin
      if (y_q >= 0) begin
        x_q   <= x_q + ys;
        y_q   <= y_q - xs;
        acc_q <= acc_q + AtanTab[cmd_i.step];
      end else begin
        x_q   <= x_q - ys;
        y_q   <= y_q + xs;
        acc_q <= acc_q - AtanTab[cmd_i.step];
      end
    end else if (cmd_i.mul) begin
      // gain removal, split into high and low parts
      phi_q <= DataW'(mag[DataW-1:FracW] * InvGain);
      plo_q <= DataW'(mag[FracW-1:0] * InvGain);
      azi_q <= AziW'(azi_a);
    end else if (cmd_i.zinit) begin
      x_q   <= dzw;
      y_q   <= $signed(phi_q + (plo_q >> FracW));
      acc_q <= '0;
    end
  end

  // result register
  assign out_free = !pair.valid || pair.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair.valid <= 1'b0;
    end else if (cmd_i.fin && out_free) begin
      pair.valid <= 1'b1;
    end else if (pair.ready) begin
      pair.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin && out_free) begin
      pair.zenith_angle  <= vert_q ? '0 : zen_c;
      pair.azimuth_angle <= vert_q ? '0 : azi_q;
      pair.upper_id      <= up_id_q;
      pair.lower_id      <= lo_id_q;
      pair.upper_charge  <= up_ch_q;
      pair.lower_charge  <= lo_ch_q;
      pair.upper_time    <= up_t_q;
      pair.lower_time    <= lo_t_q;
      pair.group_time    <= grp_t_q;
      pair.charge_sum    <= (QW+1)'(up_ch_q) + (QW+1)'(lo_ch_q);
    end
  end

  assign hit.ready = cmd_i.ready;

endmodule

`default_nettype wire

>>> rtl/core/side_hit_pair_direction_unit.sv
// ---------------------------------------------------------------------------
// side_hit_pair_direction_unit
// groups time-ordered hits and gives the direction of a two-side-hit pair
// ---------------------------------------------------------------------------
// usage
//   hit_i   : valid/ready sink, one hit or end marker per beat
//   pair_o  : valid/ready source, one direction result per qualifying group
//   cfg_*   : time_tolerance written while the unit is idle
// sequencing
//   a hit that closes no qualifying group is taken while the sequencer idles;
//   the next beat can follow straight away
//   a beat that closes a qualifying pair starts the sequencer: a setup step,
//   16 azimuth cordic steps, a gain multiply, a second setup, 16 zenith steps
//   and the result write, after which hit_i is ready again (only the write
//   for a vertical pair); one shared cordic stage serves both passes, so
//   hit_i is held off meanwhile
// reset
//   no group open, no result pending, tolerance cleared
// stall
//   the result sits in the output register; hits keep being taken until
//   the next pair closes, whose result then waits for the register to free
`default_nettype none

module side_hit_pair_direction_unit
  import shpd_pkg::*;
#(
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef,
  parameter int unsigned CHARGE_BITS = ChargeBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [TolW-1:0] cfg_wdata_i,
  shpd_hit_if.sink             hit_i,
  shpd_pair_if.source          pair_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  shpd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  shpd_dp #(
    .COORD_BITS  (COORD_BITS),
    .TIME_BITS   (TIME_BITS),
    .CHARGE_BITS (CHARGE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .hit         (hit_i),
    .pair        (pair_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

>>> rtl/core/shpd_checker.sv
// ---------------------------------------------------------------------------
// shpd_checker
// port level checks of the side hit pair direction unit
// ---------------------------------------------------------------------------
`default_nettype none

module shpd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        hit_ready,
  input wire logic        pair_valid,
  input wire logic        pair_ready,
  input wire logic [12:0] zen,
  input wire logic [14:0] azi
);

  // a held result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid && !pair_ready |=> pair_valid)
    else $error("result dropped while stalled");

  // a new result only comes out of the busy sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pair_valid) |-> $past(!hit_ready))
    else $error("result without sequencer run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid |-> (zen <= 13'd5760))
    else $error("zenith out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid |-> (azi < 15'd23040))
    else $error("azimuth out of range");

endmodule

bind side_hit_pair_direction_unit shpd_checker u_shpd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .hit_ready  (hit_i.ready),
  .pair_valid (pair_o.valid),
  .pair_ready (pair_o.ready),
  .zen        (pair_o.zenith_angle),
  .azi        (pair_o.azimuth_angle)
);

`default_nettype wire

>>> tb/pair_direction_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pair_direction_checker
// watches the hit, result and tolerance ports, predicts each pair direction
// and compares every result beat with the oldest predicted one
// ---------------------------------------------------------------------------
`default_nettype none

module pair_direction_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  shpd_hit_if              hit,
  shpd_pair_if             pair,
  output int unsigned      fail_count,
  output int unsigned      pairs_pending,
  output int unsigned      pairs_seen
);

  typedef struct packed {
    logic [12:0] zen;
    logic [14:0] azi;
    logic [6:0]  up_id;
    logic [6:0]  lo_id;
    logic [31:0] up_q;
    logic [31:0] lo_q;
    logic [47:0] up_t;
    logic [47:0] lo_t;
    logic [47:0] grp_t;
    logic [32:0] q_sum;
  } pair_dir_t;

  localparam longint AtanQ16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  pair_dir_t   dir_q [$];
  logic [15:0] tol;
  bit          grp_open;
  logic [47:0] grp_start;
  int unsigned side_cnt;
  logic [6:0]  kept_id [2];
  logic [47:0] kept_t  [2];
  longint      kept_x  [2];
  longint      kept_y  [2];
  longint      kept_z  [2];
  logic [31:0] kept_q  [2];

  function automatic int side_code(input logic [6:0] id);
    if (id <= 11 || (id >= 101 && id <= 112)) return 1;
    if (id >= 12 && id <= 35) return 2;
    if ((id >= 36 && id <= 47) || (id >= 65 && id <= 76)) return 3;
    if (id >= 77 && id <= 100) return 4;
    return 0;
  endfunction

  // vectoring with x >= 0, angle in 2^-16 degree
  function automatic longint rotate_to_axis(input longint x0, input longint y0,
                                            output longint mag);
    longint x, y, xs, ys, acc;
    x = x0;
    y = y0;
    acc = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc += AtanQ16[i];
      end else begin
        x = x - ys; y = y + xs; acc -= AtanQ16[i];
      end
    end
    mag = x;
    return acc;
  endfunction

  function automatic bit pair_direction(output pair_dir_t d);
    int unsigned up, lo;
    longint dx, dy, dz, x, y, t, acc, rho, zen, azi;
    logic [63:0] m, hi, lw;
    d = '0;
    if (side_cnt != 2) return 0;
    if (side_code(kept_id[0]) == side_code(kept_id[1])) return 0;
    if (kept_z[0] == kept_z[1]) return 0;
    up = (kept_z[0] > kept_z[1]) ? 0 : 1;
    lo = 1 - up;
    dx = kept_x[up] - kept_x[lo];
    dy = kept_y[up] - kept_y[lo];
    dz = kept_z[up] - kept_z[lo];
    zen = 0;
    azi = 0;
    if (dx != 0 || dy != 0) begin
      x = dx <<< 37;
      y = dy <<< 37;
      acc = 0;
      // left half plane: quarter turn towards positive x first
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; acc = 90 * 65536;
        end else begin
          t = x; x = -y; y = t; acc = -90 * 65536;
        end
      end
      acc += rotate_to_axis(x, y, rho);
      azi = (acc + 512) >>> 10;
      if (azi < 0) azi += 23040;
      if (azi >= 23040) azi -= 23040;
      // remove cordic gain
      m = (rho > 0) ? rho : 0;
      hi = m >> 30;
      lw = m & ((64'd1 << 30) - 1);
      rho = hi * 64'd652032874 + ((lw * 64'd652032874) >> 30);
      acc = rotate_to_axis(dz <<< 37, rho, t);
      zen = acc + 512;
      zen = (zen < 0) ? 0 : (zen >>> 10);
      if (zen > 5760) zen = 5760;
    end
    d.zen   = zen[12:0];
    d.azi   = azi[14:0];
    d.up_id = kept_id[up];
    d.lo_id = kept_id[lo];
    d.up_q  = kept_q[up];
    d.lo_q  = kept_q[lo];
    d.up_t  = kept_t[up];
    d.lo_t  = kept_t[lo];
    d.grp_t = grp_start;
    d.q_sum = {1'b0, kept_q[up]} + {1'b0, kept_q[lo]};
    return 1;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic take_hit();
    pair_dir_t   d;
    logic [47:0] tdiff;
    if (hit.is_end) begin
      if (grp_open && pair_direction(d)) dir_q.insert(dir_q.size(), d);
      grp_open = 0;
      side_cnt = 0;
      return;
    end
    if (grp_open) begin
      tdiff = (hit.hit_time >= grp_start) ? hit.hit_time - grp_start
                                          : grp_start - hit.hit_time;
      if (tdiff > tol) begin
        if (pair_direction(d)) dir_q.insert(dir_q.size(), d);
        grp_open = 0;
      end
    end
    if (!grp_open) begin
      grp_open  = 1;
      grp_start = hit.hit_time;
      side_cnt  = 0;
    end
    if (side_code(hit.det_id) != 0) begin
      if (side_cnt < 2) begin
        kept_id[side_cnt] = hit.det_id;
        kept_t[side_cnt]  = hit.hit_time;
        kept_x[side_cnt]  = longint'(hit.pos_x);
        kept_y[side_cnt]  = longint'(hit.pos_y);
        kept_z[side_cnt]  = longint'(hit.pos_z);
        kept_q[side_cnt]  = hit.charge;
      end
      if (side_cnt < 3) side_cnt++;
    end
  endtask

  task automatic check_pair();
    pair_dir_t w;
    if (dir_q.size() == 0) begin
      report("unpredicted result beat", 64'd1, 64'd0);
      return;
    end
    w = dir_q.pop_front();
    pairs_seen++;
    if (pair.zenith_angle  !== w.zen)   report("zenith", pair.zenith_angle, w.zen);
    if (pair.azimuth_angle !== w.azi)   report("azimuth", pair.azimuth_angle, w.azi);
    if (pair.upper_id      !== w.up_id) report("upper_id", pair.upper_id, w.up_id);
    if (pair.lower_id      !== w.lo_id) report("lower_id", pair.lower_id, w.lo_id);
    if (pair.upper_charge  !== w.up_q)  report("upper_charge", pair.upper_charge, w.up_q);
    if (pair.lower_charge  !== w.lo_q)  report("lower_charge", pair.lower_charge, w.lo_q);
    if (pair.upper_time    !== w.up_t)  report("upper_time", pair.upper_time, w.up_t);
    if (pair.lower_time    !== w.lo_t)  report("lower_time", pair.lower_time, w.lo_t);
    if (pair.group_time    !== w.grp_t) report("group_time", pair.group_time, w.grp_t);
    if (pair.charge_sum    !== w.q_sum) report("charge_sum", pair.charge_sum, w.q_sum);
  endtask

  initial begin
    fail_count    = 0;
    pairs_seen    = 0;
    pairs_pending = 0;
    tol           = '0;
    grp_open      = 0;
    grp_start     = '0;
    side_cnt      = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pair.valid && pair.ready) check_pair();
      if (hit.valid && hit.ready) take_hit();
      // a tolerance write applies from the next beat on
      if (cfg_we_i) tol = cfg_wdata_i;
      pairs_pending = $unsigned(dir_q.size());
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// stimulus and verdict for the side hit pair direction unit: directed groups
// for the corner cases, then random groups over several tolerances and
// idling patterns, checked beat by beat by pair_direction_checker
// ---------------------------------------------------------------------------
`default_nettype none

module testbench
  import shpd_pkg::*;
();

  localparam int unsigned NoAcceptLimit = 4000;
  localparam int unsigned SettleCycles  = 60;   // outlasts a full sequencer run
  localparam int unsigned PhaseItems    = 104;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [TolW-1:0] cfg_wdata_i;

  shpd_hit_if  hit_ch ();
  shpd_pair_if pair_ch ();

  int unsigned fail_count, pairs_pending, pairs_seen;
  int unsigned hits_sent;
  int unsigned send_idle, recv_stall;   // percent
  int unsigned quiet_cycles;
  int unsigned cur_tol;
  logic [47:0] now_t;

  side_hit_pair_direction_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .hit_i      (hit_ch),
    .pair_o     (pair_ch)
  );

  pair_direction_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .hit          (hit_ch),
    .pair         (pair_ch),
    .fail_count   (fail_count),
    .pairs_pending(pairs_pending),
    .pairs_seen   (pairs_seen)
  );

  always #1 clk_i = ~clk_i;

  // result side stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_ch.ready <= 1'b0;
    end else begin
      pair_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((hit_ch.valid && hit_ch.ready) || (pair_ch.valid && pair_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= NoAcceptLimit) begin
        $display("watchdog: no beat for %0d cycles", NoAcceptLimit);
        $display("side_hit_pair_direction_unit test failed");
        $finish;
      end
    end
  end

  // one beat on the hit channel, with random idle cycles in front
  task automatic put_hit(input logic e, input logic [6:0] id, input logic [47:0] t,
                         input logic [19:0] x, input logic [19:0] y,
                         input logic [19:0] z, input logic [31:0] q);
    while ($urandom_range(99) < send_idle) begin
      hit_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    hit_ch.valid    <= 1'b1;
    hit_ch.is_end   <= e;
    hit_ch.det_id   <= id;
    hit_ch.hit_time <= t;
    hit_ch.pos_x    <= x;
    hit_ch.pos_y    <= y;
    hit_ch.pos_z    <= z;
    hit_ch.charge   <= q;
    @(posedge clk_i);
    while (!hit_ch.ready) @(posedge clk_i);
    hits_sent++;
  endtask

  // end marker, the payload is junk
  task automatic put_end();
    put_hit(1'b1, 7'($urandom), 48'({$urandom, $urandom}), 20'($urandom), 20'($urandom),
            20'($urandom), $urandom);
  endtask

  // stop sending until every predicted result has come out, then let the
  // sequencer settle
  task automatic drain();
    hit_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pairs_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_tolerance(input int unsigned v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= TolW'(v);
    cur_tol = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [6:0] side_id(input int s);
    int unsigned r;
    r = $urandom_range(23);
    case (s)
      1: begin
        return (r < 12) ? 7'(r) : 7'(101 + r - 12);
      end
      2: begin
        return 7'(12 + r);
      end
      3: begin
        return (r < 12) ? 7'(36 + r) : 7'(65 + r - 12);
      end
      default: begin
        return 7'(77 + r);
      end
    endcase
  endfunction

  function automatic logic [6:0] other_id();
    int unsigned r;
    r = $urandom_range(31);
    return (r < 17) ? 7'(48 + r) : 7'(113 + r - 17);
  endfunction

  function automatic logic [19:0] coord(input bit wide);
    int c;
    c = $urandom_range(2000);
    return wide ? 20'($urandom) : 20'(c - 1000);
  endfunction

  function automatic logic [47:0] in_window();
    return now_t + 48'($urandom_range(cur_tol));
  endfunction

  // a new group start, far enough to close whatever is open
  task automatic next_group_start();
    if ($urandom_range(19) == 0) begin
      now_t = {16'($urandom_range(16'hfffe)), $urandom};
    end else begin
      now_t = now_t + 48'(cur_tol) + 48'd1 + 48'($urandom_range(50));
    end
  endtask

  task automatic random_group();
    int unsigned kind, n;
    int s1, s2;
    bit wide;
    logic [19:0] x1, y1, z1, x2, y2, z2;
    kind = $urandom_range(99);
    next_group_start();
    wide = $urandom_range(1);
    if (kind < 70) begin
      // well formed pair from two sides, sometimes with other channels mixed in
      s1 = $urandom_range(1, 4);
      s2 = $urandom_range(1, 3);
      if (s2 >= s1) s2++;
      x1 = coord(wide); y1 = coord(wide); z1 = coord(wide);
      x2 = coord(wide); y2 = coord(wide); z2 = coord(wide);
      n = $urandom_range(19);
      if (n == 0) begin
        x2 = x1; y2 = y1;    // vertical
      end else if (n == 1) begin
        z2 = z1;             // level pair
      end
      put_hit(1'b0, side_id(s1), now_t, x1, y1, z1, $urandom);
      if ($urandom_range(3) == 0) begin
        put_hit(1'b0, other_id(), in_window(), coord(1), coord(1), coord(1), $urandom);
      end
      put_hit(1'b0, side_id(s2), in_window(), x2, y2, z2, $urandom);
      if ($urandom_range(1)) put_end();
    end else if (kind < 85) begin
      // broken: lone side hit, same side, or three side hits
      n = $urandom_range(2);
      s1 = $urandom_range(1, 4);
      put_hit(1'b0, side_id(s1), now_t, coord(wide), coord(wide), coord(wide), $urandom);
      if (n >= 1) begin
        put_hit(1'b0, side_id(n == 1 ? s1 : (s1 % 4) + 1), in_window(),
                coord(wide), coord(wide), coord(wide), $urandom);
      end
      if (n == 2) begin
        put_hit(1'b0, side_id($urandom_range(1, 4)), in_window(),
                coord(wide), coord(wide), coord(wide), $urandom);
      end
      if ($urandom_range(1)) put_end();
    end else begin
      // noise: any id, times scattered around the window
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(5) == 0) begin
          put_end();
        end else begin
          put_hit(1'b0, 7'($urandom), now_t + 48'($urandom_range(2 * cur_tol + 2)),
                  20'($urandom), 20'($urandom), 20'($urandom), $urandom);
        end
      end
    end
  endtask

  task automatic directed_part();
    // end marker while nothing is open
    put_end();
    // extreme coordinates, charges and times
    put_hit(1'b0, 7'd0, 48'hffff_ffff_ffff, 20'h7ffff, 20'h80000, 20'h7ffff, 32'hffff_ffff);
    put_hit(1'b0, 7'd35, 48'hffff_ffff_ffff, 20'h80000, 20'h7ffff, 20'h80000, 32'hffff_ffff);
    put_end();
    put_hit(1'b0, 7'd101, 48'd0, 20'h80000, 20'h80000, 20'h80000, 32'd0);
    put_hit(1'b0, 7'd77, 48'd0, 20'h7ffff, 20'h7ffff, 20'h7ffff, 32'd0);
    put_end();
    // vertical pair
    put_hit(1'b0, 7'd112, 48'd10, 20'd500, -20'sd300, 20'd900, 32'd7);
    put_hit(1'b0, 7'd36, 48'd10, 20'd500, -20'sd300, -20'sd900, 32'd9);
    put_end();
    // level pair
    put_hit(1'b0, 7'd11, 48'd20, 20'd1, 20'd2, 20'd40, 32'd1);
    put_hit(1'b0, 7'd100, 48'd20, 20'd5, 20'd6, 20'd40, 32'd2);
    put_end();
    // same side
    put_hit(1'b0, 7'd12, 48'd30, 20'd1, 20'd2, 20'd3, 32'd1);
    put_hit(1'b0, 7'd20, 48'd30, 20'd9, 20'd8, 20'd7, 32'd2);
    put_end();
    // three side hits
    put_hit(1'b0, 7'd47, 48'd40, 20'd1, 20'd2, 20'd3, 32'd1);
    put_hit(1'b0, 7'd65, 48'd40, 20'd9, 20'd8, 20'd7, 32'd2);
    put_hit(1'b0, 7'd76, 48'd40, 20'd4, 20'd4, 20'd4, 32'd3);
    put_end();
    // other channels around a good pair, closed by a hit outside the window
    put_hit(1'b0, 7'd48, 48'd50, 20'd0, 20'd0, 20'd0, 32'd0);
    put_hit(1'b0, 7'd110, 48'd50, -20'sd100, 20'd100, 20'd10, 32'd11);
    put_hit(1'b0, 7'd127, 48'd50, 20'd0, 20'd0, 20'd0, 32'd0);
    put_hit(1'b0, 7'd89, 48'd50, 20'd100, -20'sd100, -20'sd10, 32'd12);
    put_hit(1'b0, 7'd64, 48'd51, 20'd0, 20'd0, 20'd0, 32'd0);
    put_end();
  endtask

  int unsigned tol_tab [6];

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    hit_ch.valid = 1'b0;
    hit_ch.is_end = 1'b0;
    hit_ch.det_id = '0;
    hit_ch.hit_time = '0;
    hit_ch.pos_x = '0;
    hit_ch.pos_y = '0;
    hit_ch.pos_z = '0;
    hit_ch.charge = '0;
    pair_ch.ready = 1'b0;
    hits_sent    = 0;
    send_idle    = 0;
    recv_stall   = 0;
    quiet_cycles = 0;
    cur_tol      = 0;
    now_t        = '0;
    tol_tab = '{0, 65535, 300, $urandom_range(65535), 1, 5000};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_tolerance(0);
    directed_part();

    for (int p = 0; p < 6; p++) begin
      drain();
      set_tolerance(tol_tab[p]);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 18; recv_stall = 18; end
      endcase
      for (int i = 0; i < PhaseItems; i = i) begin
        int unsigned before_cnt;
        before_cnt = hits_sent;
        random_group();
        i += hits_sent - before_cnt;
        // sender holds off once until the unit has emptied
        if (p == 2 && i >= PhaseItems / 2 && i - (hits_sent - before_cnt) < PhaseItems / 2) begin
          drain();
        end
      end
    end

    put_end();
    drain();

    $display("sent %0d hit beats, checked %0d pair results", hits_sent, pairs_seen);
    $display("tolerances 0 to 65535, idle and stall phases of 0, 18 and 69 percent");
    if (fail_count == 0) begin
      $display("side_hit_pair_direction_unit test passed");
    end else begin
      $display("side_hit_pair_direction_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
